// File: hw/rtl/nnue_pkg.sv
// Shared constants, item codes and controller/datapath interface types.
package nnue_pkg;

   localparam int NEURONS  = 32;
   localparam int FEATURES = 1024;

   // item field widths
   localparam int KIND_W = 3;
   localparam int FEAT_W = 10;
   localparam int NRN_W  = 5;
   localparam int VAL_W  = 16;
   localparam int WGT_W  = 8;
   localparam int ACC_W  = 16;

   // storage address widths
   localparam int NRN_AW   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int WT_DEPTH = FEATURES * NEURONS;
   localparam int WT_AW    = $clog2(WT_DEPTH);

   // stream word widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - NRN_W - ACC_W;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD_WEIGHT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_BIAS   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REFRESH     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ADD         = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ        = 3'd5;

   typedef struct packed {
      logic capture;   // latch the incoming word
      logic clr_cnt;   // restart the neuron walk
      logic walk;      // issue reads at the walk index, advance it
      logic wr_one;    // single weight or bias write
      logic rd_one;    // read one accumulator element
      logic load_out;  // move read data into the result register
   } nnue_cmd_type;

   typedef struct packed {
      logic cnt_last;  // walk index at last neuron
      logic out_full;  // result register holds a word
   } nnue_sts_type;

endpackage

// File: hw/rtl/nnue_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module nnue_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/nnue_ctrl.sv
// Controller state machine: sequences loads, neuron walks and reads.
module nnue_ctrl
   import nnue_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [KIND_W-1:0] req_kind,
   input  logic              rsp_tready,
   input  nnue_sts_type      sts,
   output logic              req_tready,
   output nnue_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WR    = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_RDA   = 3'd4;
   localparam logic [2:0] S_RDO   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       ready;

   always_comb begin
      state_in = state_ff;
      ready    = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            // a read waits only while the result register cannot drain
            ready = !((req_kind == KIND_READ) && sts.out_full && !rsp_tready);
            if (req_tvalid && ready) begin
               cmd.capture = 1'b1;
               cmd.clr_cnt = 1'b1;
               unique case (req_kind)
                  KIND_LOAD_WEIGHT, KIND_LOAD_BIAS:   state_in = S_WR;
                  KIND_REFRESH, KIND_ADD, KIND_REMOVE: state_in = S_WALK;
                  KIND_READ:                          state_in = S_RDA;
                  default:                            state_in = S_IDLE;
               endcase
            end
         end
         S_WR: begin
            cmd.wr_one = 1'b1;
            state_in   = S_IDLE;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;  // last accumulator write lands here
         end
         S_RDA: begin
            cmd.rd_one = 1'b1;
            state_in   = S_RDO;
         end
         S_RDO: begin
            cmd.load_out = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/nnue_dp.sv
// Datapath: weight, bias and accumulator RAMs, walk counter, result register.
module nnue_dp
   import nnue_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  nnue_cmd_type      cmd,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [FEAT_W-1:0] req_feature,
   input  logic [NRN_W-1:0]  req_neuron,
   input  logic [VAL_W-1:0]  req_value,
   input  logic              rsp_tready,
   output nnue_sts_type      sts,
   output logic              rsp_tvalid,
   output logic [NRN_W-1:0]  rsp_neuron,
   output logic [ACC_W-1:0]  rsp_acc
);

   localparam logic [WT_AW-1:0]  NRN_WT   = WT_AW'(NEURONS);
   localparam logic [NRN_AW-1:0] CNT_LAST = NRN_AW'(NEURONS - 1);
   localparam logic [NRN_AW-1:0] CNT_ONE  = NRN_AW'(1);

   // captured item
   logic [KIND_W-1:0] kind_ff;
   logic [NRN_W-1:0]  neuron_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [WT_AW-1:0]  base_ff;
   logic              row_ok_ff;
   logic              nrn_ok_ff;

   // walk pipeline
   logic [NRN_AW-1:0] cnt_ff;
   logic [NRN_AW-1:0] wr_idx_ff;
   logic              rd_valid_ff;

   // result register
   logic              out_valid_ff;
   logic [NRN_W-1:0]  out_neuron_ff;
   logic [ACC_W-1:0]  out_acc_ff;

   logic [NRN_AW-1:0] nrn_idx;
   logic [WGT_W-1:0]  wt_rd;
   logic [ACC_W-1:0]  bias_rd;
   logic [ACC_W-1:0]  acc_rd;
   logic [ACC_W-1:0]  wt_ext;
   logic [ACC_W-1:0]  acc_wdata;
   logic              wt_we;
   logic              bias_we;
   logic              acc_we;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         neuron_ff <= req_neuron;
         value_ff  <= req_value;
         base_ff   <= WT_AW'(req_feature) * NRN_WT;
         row_ok_ff <= (32'(req_feature) < FEATURES);
         nrn_ok_ff <= (32'(req_neuron) < NEURONS);
      end
      if (cmd.clr_cnt) begin
         cnt_ff <= '0;
      end else if (cmd.walk) begin
         cnt_ff <= cnt_ff + CNT_ONE;
      end
      wr_idx_ff <= cnt_ff;
      if (cmd.load_out) begin
         out_neuron_ff <= neuron_ff;
         out_acc_ff    <= nrn_ok_ff ? acc_rd : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.walk;
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign nrn_idx = NRN_AW'(neuron_ff);
   assign wt_we   = cmd.wr_one && (kind_ff == KIND_LOAD_WEIGHT) && row_ok_ff && nrn_ok_ff;
   assign bias_we = cmd.wr_one && (kind_ff == KIND_LOAD_BIAS) && nrn_ok_ff;

   // refresh copies the bias; add and remove skip rows beyond the table
   assign acc_we  = rd_valid_ff && ((kind_ff == KIND_REFRESH) || row_ok_ff);
   assign wt_ext  = {{(ACC_W - WGT_W){wt_rd[WGT_W-1]}}, wt_rd};

   always_comb begin
      priority if (kind_ff == KIND_REFRESH) begin
         acc_wdata = bias_rd;
      end else if (kind_ff == KIND_REMOVE) begin
         acc_wdata = acc_rd - wt_ext;
      end else begin
         acc_wdata = acc_rd + wt_ext;
      end
   end

   nnue_ram #(.WIDTH(WGT_W), .DEPTH(WT_DEPTH)) u_wt_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (base_ff + WT_AW'(neuron_ff)),
      .wr_data (value_ff[WGT_W-1:0]),
      .rd_en   (cmd.walk),
      .rd_addr (base_ff + WT_AW'(cnt_ff)),
      .rd_data (wt_rd)
   );

   nnue_ram #(.WIDTH(ACC_W), .DEPTH(NEURONS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (nrn_idx),
      .wr_data (value_ff),
      .rd_en   (cmd.walk),
      .rd_addr (cnt_ff),
      .rd_data (bias_rd)
   );

   nnue_ram #(.WIDTH(ACC_W), .DEPTH(NEURONS)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (wr_idx_ff),
      .wr_data (acc_wdata),
      .rd_en   (cmd.walk || cmd.rd_one),
      .rd_addr (cmd.rd_one ? nrn_idx : cnt_ff),
      .rd_data (acc_rd)
   );

   assign sts.cnt_last = (cnt_ff == CNT_LAST);
   assign sts.out_full = out_valid_ff;
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_neuron   = out_neuron_ff;
   assign rsp_acc      = out_acc_ff;

endmodule

// File: hw/rtl/nnue_accumulator_update.sv
// Top level of the incremental NNUE first-layer accumulator.
//
// Request stream (req_*): one word per command. tuser carries the kind
// (load weight, load bias, refresh, add feature, remove feature, read);
// tdata carries feature, neuron and value. Response stream (rsp_*): one
// word per read, holding the neuron index and the int16 element.
//
// Each word is accepted only in idle, so a command finishes before the next
// is taken: loads write one entry, refresh / add / remove walk all NEURONS
// neurons, a read fetches the element and loads it into the response
// register, and unused kinds return straight to idle.
// The walk is bounded by the accumulator RAM: one element read and one
// written per cycle, each write following in the cycle after its read.
//
// Reset clears the controller and the response valid; RAM contents are
// not cleared, so weights and biases must be loaded and the accumulator
// refreshed before use. A stalled response sits in its output register;
// commands keep being accepted, only a new read waits until that
// register drains.
module nnue_accumulator_update
   import nnue_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // feature[9:0] neuron[14:10] value[30:15]
   input  logic [KIND_W-1:0]     req_tuser,   // kind[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // neuron_out[4:0] acc_value[20:5]
);

   nnue_cmd_type     cmd;
   nnue_sts_type     sts;
   logic [NRN_W-1:0] rsp_neuron;
   logic [ACC_W-1:0] rsp_acc;

   nnue_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   nnue_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_kind    (req_tuser),
      .req_feature (req_tdata[FEAT_W-1:0]),
      .req_neuron  (req_tdata[FEAT_W+NRN_W-1:FEAT_W]),
      .req_value   (req_tdata[FEAT_W+NRN_W+VAL_W-1:FEAT_W+NRN_W]),
      .rsp_tready  (rsp_tready),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_neuron  (rsp_neuron),
      .rsp_acc     (rsp_acc)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_acc, rsp_neuron};

endmodule

// File: hw/rtl/nnue_chk.sv
// Port-level assertion checker for the accumulator block, with its bind.
module nnue_chk
   import nnue_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [KIND_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // an accepted read is answered once the element read and the result load are through
   a_read_lat: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser == KIND_READ) |-> ##3 rsp_tvalid)
      else $error("read response missing");

   // only reads produce responses
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser != KIND_READ) |=> !$rose(rsp_tvalid))
      else $error("response without a read");

   // every real command keeps the block busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser <= KIND_READ) |=> !req_tready)
      else $error("accepted a word while busy");

endmodule

bind nnue_accumulator_update nnue_chk u_nnue_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
